>>> sv/prg_pkg.sv
// ----------------------------------------------------------------------------
// prg_pkg
// Shared widths, codes and pipeline word types of the primary ray generator.
// ----------------------------------------------------------------------------
package prg_pkg;

  // Camera vector components and viewport coordinates
  localparam int COORD_WIDTH  = 21;
  localparam int UV_FRAC_BITS = 15;
  localparam int UV_W         = 16;
  localparam int REG_W        = 63;
  localparam int CFG_IDX_W    = 2;

  // Output direction format, signed Q1.15
  localparam int DIR_W    = 16;
  localparam int DIR_FRAC = 15;
  localparam logic [DIR_W-1:0] DIR_MAX = DIR_W'((1 << (DIR_W - 1)) - 1);

  // Unnormalized direction: offset term and product terms
  localparam int PROD_W = COORD_WIDTH + UV_W + 1;
  localparam int OFS_W  = COORD_WIDTH + 1 + UV_FRAC_BITS;
  localparam int D_W    = ((PROD_W > OFS_W) ? PROD_W : OFS_W) + 2;
  localparam int MAG_W  = D_W;
  localparam int SHIFT_W = $clog2(MAG_W);

  // Normalized magnitudes lie in [0, 2^30)
  localparam int NORM_MSB   = 29;
  localparam int NORM_W     = NORM_MSB + 1;
  localparam int SUM_W      = 2 * NORM_W + 2;
  localparam int LEN_W      = NORM_W + 1;
  localparam int SQRT_STEPS = SUM_W / 2;

  // Restoring divider
  localparam int QUO_W     = DIR_FRAC + 1;
  localparam int NUM_W     = NORM_W + DIR_FRAC + 2;
  localparam int DIV_STEPS = QUO_W;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN     = 2'd0,
    REG_LOWER_LEFT = 2'd1,
    REG_HORIZ      = 2'd2,
    REG_VERT       = 2'd3
  } cfg_reg_t;

  typedef logic [2:0][COORD_WIDTH-1:0] vec_t;

  // Word leaving the front end
  typedef struct packed {
    logic [2:0][NORM_W-1:0] mag;
    logic [2:0]             neg;
    logic                   degen;
    logic [SUM_W-1:0]       sum;
  } norm_t;

  // Word leaving the square root
  typedef struct packed {
    logic [2:0][NORM_W-1:0] mag;
    logic [2:0]             neg;
    logic                   degen;
    logic [LEN_W-1:0]       len;
  } unit_t;

  // Result word
  typedef struct packed {
    logic [2:0][DIR_W-1:0] dir;
    logic                  degen;
  } dir_t;

  // Pick component k (x, y, z) out of a packed register
  function automatic logic [COORD_WIDTH-1:0] get_comp(input logic [REG_W-1:0] r,
                                                      input int k);
    get_comp = r[k*COORD_WIDTH +: COORD_WIDTH];
  endfunction

endpackage

>>> sv/prg_front.sv
// ----------------------------------------------------------------------------
// prg_front
// Forms the unnormalized ray direction, takes magnitudes, normalizes them to
// a common exponent and sums their squares. Seven register stages.
// ----------------------------------------------------------------------------
module prg_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [prg_pkg::UV_W-1:0]      u,
  input  logic [prg_pkg::UV_W-1:0]      v,
  input  prg_pkg::vec_t                 origin,
  input  prg_pkg::vec_t                 lower_left,
  input  prg_pkg::vec_t                 horiz,
  input  prg_pkg::vec_t                 vert,
  output logic                          out_valid,
  output prg_pkg::norm_t                out_data
);
  import prg_pkg::*;

  localparam int STAGES = 7;
  localparam int EXT_W  = D_W - OFS_W;

  logic [STAGES-1:0] vld;

  logic signed [PROD_W-1:0]    a_hprod [3];
  logic signed [PROD_W-1:0]    a_vprod [3];
  logic signed [COORD_WIDTH:0] a_diff  [3];
  logic [D_W-1:0]              b_d     [3];
  logic [MAG_W-1:0]            c_mag   [3];
  logic [2:0]                  c_neg;
  logic [MAG_W-1:0]            c_max;
  logic [MAG_W-1:0]            c_mag_next [3];
  logic [MAG_W-1:0]            c_max_next;
  logic [MAG_W-1:0]            d_mag   [3];
  logic [2:0]                  d_neg;
  logic                        d_degen;
  logic [SHIFT_W-1:0]          d_p;
  logic [SHIFT_W-1:0]          d_p_next;
  logic [NORM_W-1:0]           e_m     [3];
  logic [2:0]                  e_neg;
  logic                        e_degen;
  logic [MAG_W+NORM_MSB-1:0]   e_shift [3];
  logic [2*NORM_W-1:0]         f_sq    [3];
  logic [NORM_W-1:0]           f_m     [3];
  logic [2:0]                  f_neg;
  logic                        f_degen;
  logic [SUM_W-1:0]            g_sum;
  logic [NORM_W-1:0]           g_m     [3];
  logic [2:0]                  g_neg;
  logic                        g_degen;

  // Advance valid bits with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[STAGES-2:0], in_valid};
    end
  end

  // Stage A: products and corner-minus-origin
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        a_hprod[k] <= $signed({1'b0, u}) * $signed(horiz[k]);
        a_vprod[k] <= $signed({1'b0, v}) * $signed(vert[k]);
        a_diff[k]  <= $signed({lower_left[k][COORD_WIDTH-1], lower_left[k]})
                    - $signed({origin[k][COORD_WIDTH-1], origin[k]});
      end
    end
  end

  // Stage B: exact direction components
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        b_d[k] <= {{EXT_W{a_diff[k][COORD_WIDTH]}}, a_diff[k], {UV_FRAC_BITS{1'b0}}}
                + {{(D_W-PROD_W){a_hprod[k][PROD_W-1]}}, a_hprod[k]}
                + {{(D_W-PROD_W){a_vprod[k][PROD_W-1]}}, a_vprod[k]};
      end
    end
  end

  // Stage C: magnitudes and their maximum
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      c_mag_next[k] = b_d[k][D_W-1] ? (~b_d[k] + 1'b1) : b_d[k];
    end
    c_max_next = (c_mag_next[0] > c_mag_next[1]) ? c_mag_next[0] : c_mag_next[1];
    if (c_mag_next[2] > c_max_next) begin
      c_max_next = c_mag_next[2];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        c_mag[k] <= c_mag_next[k];
        c_neg[k] <= b_d[k][D_W-1];
      end
      c_max <= c_max_next;
    end
  end

  // Stage D: leading one of the maximum
  always_comb begin
    d_p_next = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (c_max[i]) begin
        d_p_next = SHIFT_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_mag   <= c_mag;
      d_neg   <= c_neg;
      d_p     <= d_p_next;
      d_degen <= (c_max == '0);
    end
  end

  // Stage E: shift so the largest magnitude has its top bit at NORM_MSB
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      e_shift[k] = {d_mag[k], {NORM_MSB{1'b0}}} >> d_p;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        e_m[k] <= e_shift[k][NORM_W-1:0];
      end
      e_neg   <= d_neg;
      e_degen <= d_degen;
    end
  end

  // Stage F: squares
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        f_sq[k] <= e_m[k] * e_m[k];
      end
      f_m     <= e_m;
      f_neg   <= e_neg;
      f_degen <= e_degen;
    end
  end

  // Stage G: sum of squares
  always_ff @(posedge clk) begin
    if (en) begin
      g_sum   <= SUM_W'(f_sq[0]) + SUM_W'(f_sq[1]) + SUM_W'(f_sq[2]);
      g_m     <= f_m;
      g_neg   <= f_neg;
      g_degen <= f_degen;
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      out_data.mag[k] = g_m[k];
    end
    out_data.neg   = g_neg;
    out_data.degen = g_degen;
    out_data.sum   = g_sum;
  end

  assign out_valid = vld[STAGES-1];

endmodule

>>> sv/prg_isqrt.sv
// ----------------------------------------------------------------------------
// prg_isqrt
// Pipelined digit-by-digit integer square root of the sum of squares, one
// result bit per register stage.
// ----------------------------------------------------------------------------
module prg_isqrt (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  prg_pkg::norm_t in_data,
  output logic           out_valid,
  output prg_pkg::unit_t out_data
);
  import prg_pkg::*;

  logic [SQRT_STEPS-1:0]  vld;
  logic [SUM_W-1:0]       x_q   [SQRT_STEPS];
  logic [SUM_W-1:0]       r_q   [SQRT_STEPS];
  logic [2:0][NORM_W-1:0] mag_q [SQRT_STEPS];
  logic [2:0]             neg_q [SQRT_STEPS];
  logic                   dg_q  [SQRT_STEPS];

  // Advance valid bits with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[SQRT_STEPS-2:0], in_valid};
    end
  end

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_step
    localparam logic [SUM_W-1:0] BIT_W = SUM_W'(1) << (2 * (SQRT_STEPS - 1 - i));

    logic [SUM_W-1:0]       x_in;
    logic [SUM_W-1:0]       r_in;
    logic [2:0][NORM_W-1:0] mag_in;
    logic [2:0]             neg_in;
    logic                   dg_in;
    logic [SUM_W-1:0]       trial;
    logic [SUM_W-1:0]       x_next;
    logic [SUM_W-1:0]       r_next;

    if (i == 0) begin : g_first
      assign x_in   = in_data.sum;
      assign r_in   = '0;
      assign mag_in = in_data.mag;
      assign neg_in = in_data.neg;
      assign dg_in  = in_data.degen;
    end else begin : g_rest
      assign x_in   = x_q[i-1];
      assign r_in   = r_q[i-1];
      assign mag_in = mag_q[i-1];
      assign neg_in = neg_q[i-1];
      assign dg_in  = dg_q[i-1];
    end

    // Try to subtract the next root bit
    always_comb begin
      trial = r_in + BIT_W;
      if (x_in >= trial) begin
        x_next = x_in - trial;
        r_next = (r_in >> 1) + BIT_W;
      end else begin
        x_next = x_in;
        r_next = r_in >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_q[i]   <= x_next;
        r_q[i]   <= r_next;
        mag_q[i] <= mag_in;
        neg_q[i] <= neg_in;
        dg_q[i]  <= dg_in;
      end
    end
  end

  always_comb begin
    out_data.mag   = mag_q[SQRT_STEPS-1];
    out_data.neg   = neg_q[SQRT_STEPS-1];
    out_data.degen = dg_q[SQRT_STEPS-1];
    out_data.len   = r_q[SQRT_STEPS-1][LEN_W-1:0];
  end

  assign out_valid = vld[SQRT_STEPS-1];

endmodule

>>> sv/prg_div.sv
// ----------------------------------------------------------------------------
// prg_div
// Three-lane pipelined restoring divider: each component magnitude, scaled by
// 2^15 and rounded half up, over the length. Saturates and applies sign.
// ----------------------------------------------------------------------------
module prg_div (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  prg_pkg::unit_t in_data,
  output logic           out_valid,
  output prg_pkg::dir_t  out_data
);
  import prg_pkg::*;

  logic [DIV_STEPS-1:0]  vld;
  logic [2:0][NUM_W-1:0] rem_q [DIV_STEPS];
  logic [2:0][QUO_W-1:0] quo_q [DIV_STEPS];
  logic [LEN_W-1:0]      len_q [DIV_STEPS];
  logic [2:0]            neg_q [DIV_STEPS];
  logic                  dg_q  [DIV_STEPS];

  // Advance valid bits with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DIV_STEPS-2:0], in_valid};
    end
  end

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
    localparam int QB = QUO_W - 1 - i;

    logic [2:0][NUM_W-1:0] rem_in;
    logic [2:0][QUO_W-1:0] quo_in;
    logic [LEN_W-1:0]      len_in;
    logic [2:0]            neg_in;
    logic                  dg_in;
    logic [NUM_W-1:0]      dsr;
    logic [2:0][NUM_W-1:0] rem_next;
    logic [2:0][QUO_W-1:0] quo_next;

    if (i == 0) begin : g_first
      // Numerator: magnitude scaled to Q15 plus half the length
      always_comb begin
        for (int k = 0; k < 3; k++) begin
          rem_in[k] = (NUM_W'(in_data.mag[k]) << DIR_FRAC)
                    + NUM_W'(in_data.len >> 1);
        end
      end
      assign quo_in = '0;
      assign len_in = in_data.len;
      assign neg_in = in_data.neg;
      assign dg_in  = in_data.degen;
    end else begin : g_rest
      assign rem_in = rem_q[i-1];
      assign quo_in = quo_q[i-1];
      assign len_in = len_q[i-1];
      assign neg_in = neg_q[i-1];
      assign dg_in  = dg_q[i-1];
    end

    // Compare against the shifted divisor and subtract per lane
    always_comb begin
      dsr = NUM_W'(len_in) << QB;
      for (int k = 0; k < 3; k++) begin
        if (rem_in[k] >= dsr) begin
          rem_next[k] = rem_in[k] - dsr;
          quo_next[k] = quo_in[k] | (QUO_W'(1) << QB);
        end else begin
          rem_next[k] = rem_in[k];
          quo_next[k] = quo_in[k];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[i] <= rem_next;
        quo_q[i] <= quo_next;
        len_q[i] <= len_in;
        neg_q[i] <= neg_in;
        dg_q[i]  <= dg_in;
      end
    end
  end

  // Saturate, apply sign, force zero on a degenerate vector
  always_comb begin
    logic [DIR_W-1:0] sat;
    for (int k = 0; k < 3; k++) begin
      sat = (quo_q[DIV_STEPS-1][k] > DIR_MAX) ? DIR_MAX : quo_q[DIV_STEPS-1][k];
      if (dg_q[DIV_STEPS-1]) begin
        out_data.dir[k] = '0;
      end else if (neg_q[DIV_STEPS-1][k]) begin
        out_data.dir[k] = ~sat + 1'b1;
      end else begin
        out_data.dir[k] = sat;
      end
    end
    out_data.degen = dg_q[DIV_STEPS-1];
  end

  assign out_valid = vld[DIV_STEPS-1];

endmodule

>>> sv/primary_ray_generator.sv
// ----------------------------------------------------------------------------
// primary_ray_generator
// Pinhole camera primary ray direction: lower_left + u*horizontal +
// v*vertical - origin, normalized to a unit vector in signed Q1.15.
// ----------------------------------------------------------------------------
// Takes one (u, v) word per clock and returns one direction word per clock
// while the output is not stalled. A word passes 7 front-end stages (products,
// sum, magnitude, leading-one search, normalize shift, squares, sum of squares),
// 31 square-root stages (one root bit each) and 16 divider stages (one
// quotient bit each, three lanes), plus the output register. A skid register
// behind the output lets one more word be taken while a result waits; input
// ready drops only while both hold a word. Camera registers are written
// through the cfg port and must not change while words are in flight.
module primary_ray_generator (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [prg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [prg_pkg::REG_W-1:0]        cfg_data,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [31:0]                      s_axis_tdata,  // u_coord, v_coord
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [47:0]                      m_axis_tdata,  // dir_x, dir_y, dir_z
  output logic                             m_axis_tuser   // degenerate
);
  import prg_pkg::*;

  logic [REG_W-1:0] camera_origin;
  logic [REG_W-1:0] lower_left_corner;
  logic [REG_W-1:0] horizontal_span;
  logic [REG_W-1:0] vertical_span;
  vec_t             origin_v;
  vec_t             lower_left_v;
  vec_t             horiz_v;
  vec_t             vert_v;

  logic   en;
  logic   front_valid;
  norm_t  front_data;
  logic   root_valid;
  unit_t  root_data;
  logic   div_valid;
  dir_t   div_data;
  logic   out_valid;
  dir_t   out_q;
  logic   skid_valid;
  dir_t   skid_q;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      camera_origin     <= '0;
      lower_left_corner <= '0;
      horizontal_span   <= '0;
      vertical_span     <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_ORIGIN:     camera_origin     <= cfg_data;
        REG_LOWER_LEFT: lower_left_corner <= cfg_data;
        REG_HORIZ:      horizontal_span   <= cfg_data;
        REG_VERT:       vertical_span     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Unpack x, y, z components
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      origin_v[k]     = get_comp(camera_origin, k);
      lower_left_v[k] = get_comp(lower_left_corner, k);
      horiz_v[k]      = get_comp(horizontal_span, k);
      vert_v[k]       = get_comp(vertical_span, k);
    end
  end

  // Pipeline moves whenever the skid register is free
  assign en            = !skid_valid;
  assign s_axis_tready = en;

  prg_front u_front (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (s_axis_tvalid),
    .u          (s_axis_tdata[15:0]),
    .v          (s_axis_tdata[31:16]),
    .origin     (origin_v),
    .lower_left (lower_left_v),
    .horiz      (horiz_v),
    .vert       (vert_v),
    .out_valid  (front_valid),
    .out_data   (front_data)
  );

  prg_isqrt u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (front_valid),
    .in_data   (front_data),
    .out_valid (root_valid),
    .out_data  (root_data)
  );

  prg_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (root_valid),
    .in_data   (root_data),
    .out_valid (div_valid),
    .out_data  (div_data)
  );

  // Output register with skid: hold a word in skid while the output stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (!out_valid || m_axis_tready) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (!out_valid || m_axis_tready) begin
      out_valid <= div_valid;
    end else if (div_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (!out_valid || m_axis_tready) begin
        out_q <= skid_q;
      end
    end else if (!out_valid || m_axis_tready) begin
      out_q <= div_data;
    end else begin
      skid_q <= div_data;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_q.dir;
  assign m_axis_tuser  = out_q.degen;

endmodule

>>> sv/prg_checker.sv
// ----------------------------------------------------------------------------
// prg_port_checker
// Port-level checks of the primary ray generator, bound to the top level.
// ----------------------------------------------------------------------------
module prg_port_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  // Input may only stall while a finished word waits at the output
  a_ready_only_on_backpressure: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no output word pending");

  // A stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("output word changed while stalled");

  // A degenerate vector gives a zero direction
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 48'd0)
    else $error("degenerate word with nonzero direction");

  // Saturation never yields the most negative code
  a_no_min_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[15:0] != 16'h8000 && m_axis_tdata[31:16] != 16'h8000
      && m_axis_tdata[47:32] != 16'h8000)
    else $error("direction component at -1.0");

endmodule

bind primary_ray_generator prg_port_checker u_prg_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
